/* hw/rtl/bqh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bqh_pkg: shared definitions for the bit-quad hole counter
// Sizes, register indexes, reset values and the word passed from the raster
// scan stage to the corner counting stage.
// ----------------------------------------------------------------------------
package bqh_pkg;

	// Longest row the line buffer holds.
	localparam int MAX_WIDTH    = 4096;
	localparam int HEIGHT_LIMIT = 4096;

	// Field and register widths.
	localparam int PIXEL_W = 8;
	localparam int CFG_W   = 13;
	localparam int COUNT_W = 24;

	// Position counters and the widths used to compare against a frame size.
	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
	localparam int WCMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
	localparam int HCMP_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

	// Configuration register indexes.
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	// Pixel as it leaves the scan stage.
	typedef struct packed {
		logic             valid;     // a pixel was accepted in the previous cycle
		logic             white;     // pixel is nonzero
		logic             window;    // its 2x2 window lies inside the counted area
		logic             row_end;   // last pixel of a row
		logic             frame_end; // last pixel of the frame
		logic [COL_W-1:0] col;       // column, also the line buffer address
	} scan_t;

endpackage
`default_nettype wire

/* hw/rtl/bqh_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bqh_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module bqh_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/bqh_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bqh_scan: configuration registers and raster position tracking
// Holds the frame size, follows the column and row of each incoming pixel,
// issues the line buffer read for the pixel above and flags the window,
// row end and frame end for the counting stage.
// ----------------------------------------------------------------------------
module bqh_scan (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic                          cfg_index,
	input  wire logic [bqh_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [bqh_pkg::PIXEL_W-1:0]   pixel,
	input  wire logic                          out_busy,
	output logic                               rd_en,
	output logic      [bqh_pkg::COL_W-1:0]     rd_addr,
	output bqh_pkg::scan_t                     scan_s1
);

	logic [bqh_pkg::CFG_W-1:0]  width_q;
	logic [bqh_pkg::CFG_W-1:0]  height_q;
	logic [bqh_pkg::COL_W-1:0]  col_q;
	logic [bqh_pkg::ROW_W-1:0]  row_q;

	logic [bqh_pkg::WCMP_W-1:0] width_full;
	logic [bqh_pkg::WCMP_W-1:0] width_sat;
	logic [bqh_pkg::HCMP_W-1:0] height_full;
	logic [bqh_pkg::HCMP_W-1:0] height_sat;
	logic [bqh_pkg::COL_W-1:0]  last_col;
	logic [bqh_pkg::ROW_W-1:0]  last_row;
	logic [bqh_pkg::COL_W-1:0]  col_cur;
	logic [bqh_pkg::ROW_W-1:0]  row_cur;
	logic                       row_end;
	logic                       frame_end;
	logic                       window;
	logic                       accept;

	// Frame size saturated to the supported range, and the current position
	// pulled back inside it should the size have shrunk.
	always_comb begin
		width_full  = bqh_pkg::WCMP_W'(width_q);
		height_full = bqh_pkg::HCMP_W'(height_q);
		if (width_full < bqh_pkg::WCMP_W'(2)) begin
			width_sat = bqh_pkg::WCMP_W'(2);
		end else if (width_full > bqh_pkg::WCMP_W'(bqh_pkg::MAX_WIDTH)) begin
			width_sat = bqh_pkg::WCMP_W'(bqh_pkg::MAX_WIDTH);
		end else begin
			width_sat = width_full;
		end
		if (height_full < bqh_pkg::HCMP_W'(2)) begin
			height_sat = bqh_pkg::HCMP_W'(2);
		end else if (height_full > bqh_pkg::HCMP_W'(bqh_pkg::HEIGHT_LIMIT)) begin
			height_sat = bqh_pkg::HCMP_W'(bqh_pkg::HEIGHT_LIMIT);
		end else begin
			height_sat = height_full;
		end
		last_col  = bqh_pkg::COL_W'(width_sat - bqh_pkg::WCMP_W'(1));
		last_row  = bqh_pkg::ROW_W'(height_sat - bqh_pkg::HCMP_W'(1));
		col_cur   = (col_q > last_col) ? last_col : col_q;
		row_cur   = (row_q > last_row) ? last_row : row_q;
		row_end   = (col_cur == last_col);
		frame_end = row_end && (row_cur == last_row);
		// Interior window: neither the first nor the last row or column.
		window    = (row_cur != '0) && (row_cur != last_row) &&
		            (col_cur != '0) && (col_cur != last_col);
	end

	// The word that completes a frame waits only if the result register
	// still holds the previous frame's result.
	assign in_ready = !(frame_end && out_busy);
	assign accept   = in_valid && in_ready;
	assign rd_en    = accept;
	assign rd_addr  = col_cur;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bqh_pkg::WIDTH_RESET;
			height_q <= bqh_pkg::HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				bqh_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				bqh_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Raster position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_cur + bqh_pkg::ROW_W'(1);
			end else begin
				col_q <= col_cur + bqh_pkg::COL_W'(1);
				row_q <= row_cur;
			end
		end
	end

	// Stage register towards the counting stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= '0;
		end else begin
			scan_s1.valid <= accept;
			if (accept) begin
				scan_s1.white     <= (pixel != '0);
				scan_s1.window    <= window;
				scan_s1.row_end   <= row_end;
				scan_s1.frame_end <= frame_end;
				scan_s1.col       <= col_cur;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/bqh_corner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bqh_corner: bit-quad classification and frame totals
// Forms the 2x2 window from the line buffer bit, the pixel and the two bits
// kept from the previous column, counts outer and inner corners and loads
// the result register at the end of each frame.
// ----------------------------------------------------------------------------
module bqh_corner (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire bqh_pkg::scan_t                     scan_s1,
	input  wire logic                               up_bit,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [bqh_pkg::COUNT_W-1:0]      hole_count,
	output logic        [bqh_pkg::COUNT_W-1:0]      outer_corners,
	output logic        [bqh_pkg::COUNT_W-1:0]      inner_corners,
	output logic                                    out_busy
);

	logic                          left_q;
	logic                          upper_left_q;
	logic [bqh_pkg::COUNT_W-1:0]   outer_q;
	logic [bqh_pkg::COUNT_W-1:0]   inner_q;
	logic                          out_valid_q;

	logic [2:0]                    white_count;
	logic                          is_outer;
	logic                          is_inner;
	logic signed [bqh_pkg::COUNT_W:0] diff;
	logic signed [bqh_pkg::COUNT_W:0] diff_adj;

	// Window population and classification.
	always_comb begin
		white_count = 3'(upper_left_q) + 3'(up_bit) + 3'(left_q) + 3'(scan_s1.white);
		is_outer    = scan_s1.window && (white_count == 3'd1);
		is_inner    = scan_s1.window && (white_count == 3'd3);
	end

	// Quotient by four, rounded toward zero: bias negative differences by three.
	always_comb begin
		diff     = $signed({1'b0, outer_q}) - $signed({1'b0, inner_q});
		diff_adj = diff + (diff[bqh_pkg::COUNT_W] ? (bqh_pkg::COUNT_W+1)'(3)
		                                          : (bqh_pkg::COUNT_W+1)'(0));
	end

	assign out_busy  = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;

	// Neighbour bits and corner totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= 1'b0;
			upper_left_q <= 1'b0;
			outer_q      <= '0;
			inner_q      <= '0;
		end else if (scan_s1.valid) begin
			left_q       <= scan_s1.row_end ? 1'b0 : scan_s1.white;
			upper_left_q <= scan_s1.row_end ? 1'b0 : up_bit;
			if (scan_s1.frame_end) begin
				outer_q <= '0;
				inner_q <= '0;
			end else begin
				if (is_outer && (outer_q != '1)) begin
					outer_q <= outer_q + bqh_pkg::COUNT_W'(1);
				end
				if (is_inner && (inner_q != '1)) begin
					inner_q <= inner_q + bqh_pkg::COUNT_W'(1);
				end
			end
		end
	end

	// Result register; the scan stage holds back a frame-ending word while
	// this register is still occupied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (scan_s1.valid && scan_s1.frame_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_s1.valid && scan_s1.frame_end) begin
			hole_count    <= {diff_adj[bqh_pkg::COUNT_W], diff_adj[bqh_pkg::COUNT_W:2]};
			outer_corners <= outer_q;
			inner_corners <= inner_q;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/bit_quad_hole_counter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bit_quad_hole_counter: bit-quad corner counter over a streamed frame
// Counts single-white and three-white 2x2 windows of a binarised raster
// frame and reports (outer - inner) / 4 with both totals once per frame.
// ----------------------------------------------------------------------------
// Pixels enter in raster order at one word per clock; the only state carried
// between rows is a one-bit line buffer of MAX_WIDTH entries, read at the
// pixel's column in the accept cycle and written back in the following cycle,
// so a word passes through the scan_s1 stage register into the corner totals
// and never stalls inside the block. The frame size comes from the image_width
// and image_height registers (saturated to 2..MAX_WIDTH and 2..4096) and
// should be written only between frames. The result register is loaded from
// the scan_s1 word with a frame's last pixel; while it waits unread, non-final
// pixels of the next frame flow on and only that frame's last pixel is held.
// ----------------------------------------------------------------------------
module bit_quad_hole_counter (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic                               cfg_index,
	input  wire logic        [bqh_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic        [bqh_pkg::PIXEL_W-1:0] pixel,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed      [bqh_pkg::COUNT_W-1:0] hole_count,
	output logic             [bqh_pkg::COUNT_W-1:0] outer_corners,
	output logic             [bqh_pkg::COUNT_W-1:0] inner_corners
);

	bqh_pkg::scan_t              scan_s1;
	logic                        rd_en;
	logic [bqh_pkg::COL_W-1:0]   rd_addr;
	logic                        up_bit;
	logic                        out_busy;

	// Position tracking and line buffer addressing.
	bqh_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.out_busy  (out_busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.scan_s1   (scan_s1)
	);

	// Line buffer: one bit per column of the previous row. Consecutive
	// words always sit at different columns, so a read never meets the
	// write still in flight.
	bqh_ram #(
		.WIDTH (1),
		.DEPTH (bqh_pkg::MAX_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (scan_s1.valid),
		.waddr (scan_s1.col),
		.wdata (scan_s1.white),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (up_bit)
	);

	// Window classification, totals and result register.
	bqh_corner u_corner (
		.clk           (clk),
		.arst_n        (arst_n),
		.scan_s1       (scan_s1),
		.up_bit        (up_bit),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hole_count    (hole_count),
		.outer_corners (outer_corners),
		.inner_corners (inner_corners),
		.out_busy      (out_busy)
	);

endmodule
`default_nettype wire
